// File: src/hdc_pkg.sv
// ----------------------------------------------------------------------------
// hdc_pkg
// Shared types, codes and lookup functions of the HTTP date clock calibrator.
// ----------------------------------------------------------------------------
package hdc_pkg;

  // header block size limit and derived counter width
  localparam int MAX_HEADER_BYTES = 4096;
  localparam int BC_W             = $clog2(MAX_HEADER_BYTES + 2);

  // length of an IMF-fixdate value
  localparam int DATE_LEN = 29;

  // action codes of an input transaction
  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_END  = 2'd1;
  localparam logic [1:0] ACT_CORR = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_TIME   = 1'b1;

  // characters
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_COMMA = 8'h2c;

  // month and weekday codes for no match
  localparam logic [3:0] MONTH_NONE = 4'd12;
  localparam logic [2:0] WDAY_NONE  = 3'd7;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BYTE,
    ST_BYTE2,
    ST_PARSE0,
    ST_PARSE1,
    ST_PARSE2,
    ST_PARSE3,
    ST_EOB,
    ST_CORR
  } state_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_BYTE,
    OP_BYTE2,
    OP_PARSE0,
    OP_PARSE1,
    OP_PARSE2,
    OP_PARSE3,
    OP_EOB,
    OP_CORR
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    op_t  op;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic second_byte;
    logic parse_start;
    logic out_free;
  } status_t;

  // month name to index, MONTH_NONE when unknown
  function automatic logic [3:0] month_index(input logic [23:0] name);
    logic [3:0] m;
    case (name)
      "Jan":   m = 4'd0;
      "Feb":   m = 4'd1;
      "Mar":   m = 4'd2;
      "Apr":   m = 4'd3;
      "May":   m = 4'd4;
      "Jun":   m = 4'd5;
      "Jul":   m = 4'd6;
      "Aug":   m = 4'd7;
      "Sep":   m = 4'd8;
      "Oct":   m = 4'd9;
      "Nov":   m = 4'd10;
      "Dec":   m = 4'd11;
      default: m = MONTH_NONE;
    endcase
    return m;
  endfunction

  // weekday name to index from sunday, WDAY_NONE when unknown
  function automatic logic [2:0] wday_index(input logic [23:0] name);
    logic [2:0] d;
    case (name)
      "Sun":   d = 3'd0;
      "Mon":   d = 3'd1;
      "Tue":   d = 3'd2;
      "Wed":   d = 3'd3;
      "Thu":   d = 3'd4;
      "Fri":   d = 3'd5;
      "Sat":   d = 3'd6;
      default: d = WDAY_NONE;
    endcase
    return d;
  endfunction

  // days in month, february without leap day
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] n;
    case (m)
      4'd1:                   n = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: n = 5'd30;
      default:                n = 5'd31;
    endcase
    return n;
  endfunction

  // days before the month in a common year
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd0:    n = 9'd0;
      4'd1:    n = 9'd31;
      4'd2:    n = 9'd59;
      4'd3:    n = 9'd90;
      4'd4:    n = 9'd120;
      4'd5:    n = 9'd151;
      4'd6:    n = 9'd181;
      4'd7:    n = 9'd212;
      4'd8:    n = 9'd243;
      4'd9:    n = 9'd273;
      4'd10:   n = 9'd304;
      default: n = 9'd334;
    endcase
    return n;
  endfunction

endpackage

// File: src/hdc_if.sv
// ----------------------------------------------------------------------------
// hdc_if
// Valid/ready channels of the calibrator: input transactions and results.
// ----------------------------------------------------------------------------
interface hdc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  header_byte;
  logic [33:0] local_time;
  logic [63:0] start_time;

  modport source (output valid, action, header_byte, local_time, start_time,
                  input ready);
  modport sink   (input valid, action, header_byte, local_time, start_time,
                  output ready);
endinterface

interface hdc_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic        calibrated_ok;
  logic [63:0] time_out;

  modport source (output valid, result_kind, calibrated_ok, time_out,
                  input ready);
  modport sink   (input valid, result_kind, calibrated_ok, time_out,
                  output ready);
endinterface

// File: src/hdc_ctrl.sv
// ----------------------------------------------------------------------------
// hdc_ctrl
// Controller: sequences byte scanning, date parsing, end of block and
// correction steps of the datapath.
// ----------------------------------------------------------------------------
module hdc_ctrl
  import hdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  output logic       in_ready,
  output cmd_t       cmd,
  input  status_t    status
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.op     = OP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_action)
            ACT_BYTE: state_next = ST_BYTE;
            ACT_END:  state_next = ST_EOB;
            ACT_CORR: state_next = ST_CORR;
            ACT_NONE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_BYTE: begin
        cmd.op = OP_BYTE;
        if (status.second_byte) begin
          state_next = ST_BYTE2;
        end else if (status.parse_start) begin
          state_next = ST_PARSE0;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_BYTE2: begin
        cmd.op     = OP_BYTE2;
        state_next = ST_IDLE;
      end
      ST_PARSE0: begin
        cmd.op     = OP_PARSE0;
        state_next = ST_PARSE1;
      end
      ST_PARSE1: begin
        cmd.op     = OP_PARSE1;
        state_next = ST_PARSE2;
      end
      ST_PARSE2: begin
        cmd.op     = OP_PARSE2;
        state_next = ST_PARSE3;
      end
      ST_PARSE3: begin
        cmd.op     = OP_PARSE3;
        state_next = ST_IDLE;
      end
      ST_EOB: begin
        if (status.out_free) begin
          cmd.op     = OP_EOB;
          state_next = ST_IDLE;
        end
      end
      ST_CORR: begin
        if (status.out_free) begin
          cmd.op     = OP_CORR;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: src/hdc_datapath.sv
// ----------------------------------------------------------------------------
// hdc_datapath
// Datapath: line scanner, Date value capture, fixdate parser, offset latch,
// start time correction and the result register.
// ----------------------------------------------------------------------------
module hdc_datapath
  import hdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [7:0]  header_byte,
  input  logic [33:0] local_time,
  input  logic [63:0] start_time,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        result_kind,
  output logic        calibrated_ok,
  output logic [63:0] time_out
);

  // latched transaction
  logic [7:0]  cur_byte;
  logic [33:0] local_q;
  logic [63:0] start_q;

  // calibration
  logic               offset_valid;
  logic signed [17:0] clock_offset;

  // scan state
  logic [BC_W-1:0] byte_count;
  logic [2:0]      line_bytes;
  logic            prev_cr;
  logic            prefix_match;
  logic [5:0]      value_len;
  logic [5:0]      trimmed_len;
  logic [7:0]      date_text [DATE_LEN];
  logic [1:0]      date_lines_seen;
  logic [32:0]     server_seconds;
  logic            server_ok;
  logic            scan_phase;
  logic            len_ok;

  // parser pipeline
  logic [6:0]  p_day, p_hour, p_min, p_sec;
  logic [13:0] p_year;
  logic [3:0]  p_month;
  logic [2:0]  p_wday;
  logic        p_fmt;
  logic [15:0] days;
  logic [16:0] hms;
  logic        p_ok;
  logic [32:0] prod_q;
  logic [32:0] secs_q;

  // content byte decode
  logic [7:0] cb;
  logic [7:0] tag_char;
  logic       prefix_hit, ws, take, do_content, line_end, parse_start;
  logic [5:0] vlen_inc;
  logic [2:0] lb_inc;

  always_comb begin
    cb = (cmd.op == OP_BYTE && prev_cr) ? CH_CR : cur_byte;
    case (line_bytes[1:0])
      2'd0:    tag_char = "d";
      2'd1:    tag_char = "a";
      2'd2:    tag_char = "t";
      default: tag_char = "e";
    endcase
    prefix_hit = (line_bytes < 3'd4) ? ((cb | 8'h20) == tag_char) : (cb == CH_COLON);
    ws         = (cb == CH_SPACE) || (cb == CH_TAB);
    take       = prefix_match && !(value_len == 6'd0 && ws);
    vlen_inc   = (value_len == 6'd63) ? value_len : value_len + 6'd1;
    lb_inc     = (line_bytes == 3'd7) ? line_bytes : line_bytes + 3'd1;
    do_content = (cmd.op == OP_BYTE2) ||
                 (cmd.op == OP_BYTE && !scan_phase &&
                  (prev_cr ? (cur_byte != CH_LF) : (cur_byte != CH_CR)));
    line_end   = cmd.op == OP_BYTE && !scan_phase && prev_cr && cur_byte == CH_LF;
    parse_start = line_end && line_bytes >= 3'd5 && prefix_match &&
                  date_lines_seen == 2'd0;
  end

  assign status.second_byte = cmd.op == OP_BYTE && !scan_phase && prev_cr &&
                              cur_byte != CH_LF && cur_byte != CH_CR;
  assign status.parse_start = parse_start;
  assign status.out_free    = !out_valid || out_ready;

  // fixdate field extraction
  logic        fmt_c, digits_ok;
  logic [6:0]  day_c, hour_c, min_c, sec_c;
  logic [13:0] year_c;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [6:0] two_dig(input logic [7:0] a, input logic [7:0] b);
    return 7'({3'b0, a[3:0]} * 7'd10) + {3'b0, b[3:0]};
  endfunction

  always_comb begin
    digits_ok = is_digit(date_text[5])  && is_digit(date_text[6])  &&
                is_digit(date_text[12]) && is_digit(date_text[13]) &&
                is_digit(date_text[14]) && is_digit(date_text[15]) &&
                is_digit(date_text[17]) && is_digit(date_text[18]) &&
                is_digit(date_text[20]) && is_digit(date_text[21]) &&
                is_digit(date_text[23]) && is_digit(date_text[24]);
    fmt_c = len_ok && digits_ok &&
            date_text[3] == CH_COMMA && date_text[4] == CH_SPACE &&
            date_text[7] == CH_SPACE && date_text[11] == CH_SPACE &&
            date_text[16] == CH_SPACE && date_text[19] == CH_COLON &&
            date_text[22] == CH_COLON && date_text[25] == CH_SPACE &&
            date_text[26] == "G" && date_text[27] == "M" && date_text[28] == "T";
    day_c  = two_dig(date_text[5], date_text[6]);
    hour_c = two_dig(date_text[17], date_text[18]);
    min_c  = two_dig(date_text[20], date_text[21]);
    sec_c  = two_dig(date_text[23], date_text[24]);
    year_c = 14'({7'b0, two_dig(date_text[12], date_text[13])} * 14'd100) +
             {7'b0, two_dig(date_text[14], date_text[15])};
  end

  // calendar arithmetic, years 2020 to 2100 only
  logic       leap;
  logic [4:0] dmax;
  logic [7:0] yoff;
  logic [15:0] days_c;
  logic       ok1_c;

  always_comb begin
    leap   = p_year[1:0] == 2'd0 && p_year != 14'd2100;
    dmax   = month_len(p_month) + {4'b0, (p_month == 4'd1) && leap};
    yoff   = 8'(p_year - 14'd1970);
    days_c = 16'({8'b0, yoff} * 16'd365) + 16'((9'({1'b0, yoff} + 9'd1)) >> 2) +
             {7'b0, month_start(p_month)} + {15'b0, (p_month > 4'd1) && leap} +
             {9'b0, p_day} - 16'd1;
    ok1_c  = p_fmt && p_year >= 14'd2020 && p_year <= 14'd2100 &&
             p_month != MONTH_NONE && p_wday != WDAY_NONE &&
             p_day >= 7'd1 && p_day <= {2'b0, dmax} &&
             p_hour <= 7'd23 && p_min <= 7'd59 && p_sec <= 7'd59;
  end

  // weekday by reciprocal of seven
  logic [13:0] quot7;
  logic [15:0] rem_full;
  logic [2:0]  rem7, wday_c;

  always_comb begin
    quot7    = prod_q[32:19];
    rem_full = days - 16'({2'b0, quot7} * 16'd7);
    rem7     = rem_full[2:0];
    wday_c   = (rem7 >= 3'd3) ? rem7 - 3'd3 : rem7 + 3'd4;
  end

  // end of block check
  logic signed [34:0] diff;
  logic [3:0]         raw;
  logic               cal_ok;

  always_comb begin
    diff   = $signed({2'b0, server_seconds}) - $signed({1'b0, local_q});
    raw    = {1'b0, line_bytes} + {3'b0, prev_cr};
    cal_ok = byte_count <= BC_W'(MAX_HEADER_BYTES) && local_q != 34'd0 &&
             !(!scan_phase && raw >= 4'd2) && date_lines_seen == 2'd1 &&
             server_ok && diff >= -35'sd86400 && diff <= 35'sd86400;
  end

  // start time correction
  logic [64:0] sum;
  logic [63:0] corrected;

  always_comb begin
    sum = {1'b0, start_q} + {{47{clock_offset[17]}}, clock_offset};
    if (start_q == 64'd0 || !offset_valid) begin
      corrected = start_q;
    end else begin
      corrected = sum[64] ? 64'd0 : sum[63:0];
    end
  end

  // transaction latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_byte <= header_byte;
      local_q  <= local_time;
      start_q  <= start_time;
    end
  end

  // value capture
  always_ff @(posedge clk) begin
    if (do_content && line_bytes >= 3'd5 && take && value_len < 6'(DATE_LEN)) begin
      date_text[value_len[4:0]] <= cb;
    end
  end

  // scan and calibration state
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_valid    <= 1'b0;
      clock_offset    <= '0;
      byte_count      <= '0;
      line_bytes      <= '0;
      prev_cr         <= 1'b0;
      prefix_match    <= 1'b1;
      value_len       <= '0;
      trimmed_len     <= '0;
      date_lines_seen <= '0;
      server_seconds  <= '0;
      server_ok       <= 1'b0;
      scan_phase      <= 1'b0;
      len_ok          <= 1'b0;
    end else if (cmd.op == OP_EOB) begin
      if (!offset_valid && cal_ok) begin
        offset_valid <= 1'b1;
        clock_offset <= diff[17:0];
      end
      byte_count      <= '0;
      line_bytes      <= '0;
      prev_cr         <= 1'b0;
      prefix_match    <= 1'b1;
      value_len       <= '0;
      trimmed_len     <= '0;
      date_lines_seen <= '0;
      server_seconds  <= '0;
      server_ok       <= 1'b0;
      scan_phase      <= 1'b0;
    end else if (cmd.op == OP_PARSE3) begin
      server_ok      <= p_ok && wday_c == p_wday;
      server_seconds <= (p_ok && wday_c == p_wday) ? secs_q + {16'b0, hms} : '0;
    end else begin
      if (cmd.op == OP_BYTE) begin
        if (byte_count <= BC_W'(MAX_HEADER_BYTES)) begin
          byte_count <= byte_count + BC_W'(1);
        end
        if (!scan_phase) begin
          prev_cr <= cur_byte == CH_CR;
        end
      end
      // end of line
      if (line_end) begin
        if (line_bytes == 3'd0) begin
          scan_phase <= 1'b1;
        end else begin
          if (line_bytes >= 3'd5 && prefix_match && date_lines_seen != 2'd2) begin
            date_lines_seen <= date_lines_seen + 2'd1;
          end
          line_bytes   <= '0;
          prefix_match <= 1'b1;
          value_len    <= '0;
          trimmed_len  <= '0;
        end
        len_ok <= trimmed_len == 6'(DATE_LEN);
      end
      // one content byte of the line
      if (do_content) begin
        if (line_bytes < 3'd5) begin
          if (!prefix_hit) begin
            prefix_match <= 1'b0;
          end
        end else if (take) begin
          value_len <= vlen_inc;
          if (!ws) begin
            trimmed_len <= vlen_inc;
          end
        end
        line_bytes <= lb_inc;
      end
    end
  end

  // parser stages
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_PARSE0: begin
        p_fmt   <= fmt_c;
        p_day   <= day_c;
        p_hour  <= hour_c;
        p_min   <= min_c;
        p_sec   <= sec_c;
        p_year  <= year_c;
        p_month <= month_index({date_text[8], date_text[9], date_text[10]});
        p_wday  <= wday_index({date_text[0], date_text[1], date_text[2]});
      end
      OP_PARSE1: begin
        days <= days_c;
        p_ok <= ok1_c;
        hms  <= 17'({10'b0, p_hour} * 17'd3600) + 17'({10'b0, p_min} * 17'd60) +
                {10'b0, p_sec};
      end
      OP_PARSE2: begin
        prod_q <= 33'(days * 17'd74899);
        secs_q <= 33'(days * 17'd86400);
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_EOB || cmd.op == OP_CORR) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EOB) begin
      result_kind   <= KIND_STATUS;
      calibrated_ok <= offset_valid || cal_ok;
      time_out      <= '0;
    end else if (cmd.op == OP_CORR) begin
      result_kind   <= KIND_TIME;
      calibrated_ok <= offset_valid;
      time_out      <= corrected;
    end
  end

endmodule

// File: src/http_date_clock_calibrator.sv
// ----------------------------------------------------------------------------
// http_date_clock_calibrator
// Calibrates a local clock from the Date line of an HTTP response header and
// corrects start timestamps by the latched offset.
// ----------------------------------------------------------------------------
// One transaction is taken at a time, only while the controller is idle. A
// header byte runs through the byte state, and the second byte state too
// when it follows a CR that turns out not to start a line end; the line
// end of the first Date line also runs the four stage fixdate parser. End
// of block and correction wait for a free result register; the result
// register lets the next transaction in while a result waits to be taken.
module http_date_clock_calibrator
  import hdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  hdc_in_if.sink    item,
  hdc_out_if.source result
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  hdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_action (item.action),
    .in_ready  (item.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // scanner, parser and result path
  hdc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .header_byte   (item.header_byte),
    .local_time    (item.local_time),
    .start_time    (item.start_time),
    .out_ready     (result.ready),
    .out_valid     (result.valid),
    .result_kind   (result.result_kind),
    .calibrated_ok (result.calibrated_ok),
    .time_out      (result.time_out)
  );

endmodule

// File: src/hdc_checker.sv
// ----------------------------------------------------------------------------
// hdc_checker
// Port level checks of the calibrator, bound to the top level.
// ----------------------------------------------------------------------------
module hdc_checker
  import hdc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic        calibrated_ok,
  input logic [63:0] time_out
);

  // a calibration once reported stays until reset
  logic seen_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_ok <= 1'b0;
    end else if (out_valid && out_ready && calibrated_ok) begin
      seen_ok <= 1'b1;
    end
  end

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(time_out) &&
    $stable(result_kind) && $stable(calibrated_ok))
    else $error("result changed while stalled");

  // status results carry no time
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_STATUS |-> time_out == 64'd0)
    else $error("status result with nonzero time");

  // no result straight after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // offset is never lost
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_ok |-> calibrated_ok)
    else $error("calibration lost");

endmodule

bind http_date_clock_calibrator hdc_checker u_hdc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .result_kind   (result.result_kind),
  .calibrated_ok (result.calibrated_ok),
  .time_out      (result.time_out)
);
